// File: src/gbng_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the grid bin neighbour gather unit.
// No dependencies.
package gbng_pkg;

	typedef enum logic [1:0] {
		FUNC_NEW_FRAME = 2'd0,
		FUNC_INSERT    = 2'd1,
		FUNC_QUERY     = 2'd2,
		FUNC_UNUSED    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_NEIGH = 2'd0,
		STAT_NONE  = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NEWF,
		ST_MUL,
		ST_COORD,
		ST_INS,
		ST_RESP,
		ST_QCELL,
		ST_QCNT,
		ST_QENT,
		ST_QPUSH,
		ST_QNEXT,
		ST_QEND
	} state_t;

endpackage

// File: src/gbng_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module gbng_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: src/grid_bin_neighbour_gather_unit.sv
`timescale 1ns / 1ps
// Top level of the grid bin neighbour gather unit: sequencer, position scaling,
// cell count and cell entry memories. Depends on gbng_pkg and gbng_ram.
//
// One item at a time. After reset, and after every new-frame item, a clearing
// pass zeroes the cell count memory one cell per cycle (GRID_SIDE*GRID_SIDE
// cells, 1024 by default) while no item is taken. An insert passes the multiply,
// coordinate, insert and response states. A query walks each window cell (cell,
// count, next states) and each index found (entry, push states), one read port
// per memory; results beyond the first wait on the output register on a sink stall.
module grid_bin_neighbour_gather_unit #(
	parameter int GRID_SIDE     = 32,
	parameter int CELL_CAP      = 7,
	parameter int MAX_PARTICLES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // pos_x[23:0], pos_y[47:24], particle_index[63:48]
	input  logic [1:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // neighbour_index
	output logic        m_tlast,
	output logic [1:0]  m_tuser,  // status
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	import gbng_pkg::*;

	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int ENTS  = CELLS * CELL_CAP;
	localparam int CW    = $clog2(GRID_SIDE);
	localparam int CAW   = $clog2(CELLS);
	localparam int EAW   = $clog2(ENTS);
	localparam int NW    = $clog2(CELL_CAP + 1);
	localparam logic signed [23:0] GSIDE_S = 24'(GRID_SIDE);

	state_t state_q, state_d;

	logic [4:0] density_q;
	logic [5:0] gw_q, gh_q;

	logic               [1:0]  func_q;
	logic signed        [23:0] posx_q, posy_q;
	logic               [15:0] pidx_q;
	logic signed        [29:0] prodx_q, prody_q;
	logic               [CAW-1:0] clr_q, cell_q;
	logic               [EAW-1:0] base_q;
	logic               [CW-1:0]  i_q, j_q, x1_q, y0_q, y1_q;
	logic               [NW-1:0]  n_q, e_q;
	logic               [15:0] ent_q, pend_q;
	logic                      pend_v_q;
	logic               [1:0]  res_st_q;

	logic        out_v_q, out_last_q;
	logic [15:0] out_idx_q;
	logic [1:0]  out_st_q;
	logic        out_free;

	logic            cnt_we;
	logic [CAW-1:0]  cnt_waddr, cnt_raddr;
	logic [NW-1:0]   cnt_wdata, cnt_rdata;
	logic            ent_we;
	logic [EAW-1:0]  ent_waddr, ent_raddr;
	logic [15:0]     ent_rdata;

	logic signed [23:0] fx, fy, wm1, hm1, cx, cy, x0, x1, y0, y1;
	logic [CAW-1:0]     ins_cell, q_cell;
	logic               q_empty, ins_bad;

	logic        load;
	logic [15:0] load_idx;
	logic        load_last;
	logic [1:0]  load_st;

	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_q <= 5'd1;
			gw_q      <= 6'd32;
			gh_q      <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				2'd0:    density_q <= cfg_data[4:0];
				2'd1:    gw_q      <= cfg_data;
				2'd2:    gh_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		fx  = {{2{prodx_q[29]}}, prodx_q[29:8]};
		fy  = {{2{prody_q[29]}}, prody_q[29:8]};
		wm1 = (gw_q == 6'd0) ? 24'sd0 :
			(($signed({18'd0, gw_q}) > GSIDE_S) ? GSIDE_S - 24'sd1 :
			$signed({18'd0, gw_q}) - 24'sd1);
		hm1 = (gh_q == 6'd0) ? 24'sd0 :
			(($signed({18'd0, gh_q}) > GSIDE_S) ? GSIDE_S - 24'sd1 :
			$signed({18'd0, gh_q}) - 24'sd1);
		cx  = (fx < 24'sd0) ? 24'sd0 : ((fx > wm1) ? wm1 : fx);
		cy  = (fy < 24'sd0) ? 24'sd0 : ((fy > hm1) ? hm1 : fy);
		x0  = (fx - 24'sd1 < 24'sd0) ? 24'sd0 : fx - 24'sd1;
		x1  = (fx + 24'sd1 > wm1) ? wm1 : fx + 24'sd1;
		y0  = (fy - 24'sd1 < 24'sd0) ? 24'sd0 : fy - 24'sd1;
		y1  = (fy + 24'sd1 > hm1) ? hm1 : fy + 24'sd1;
		q_empty  = (x0 > x1) || (y0 > y1);
		ins_cell = CAW'(CAW'(cy[CW-1:0]) * CAW'(GRID_SIDE) + CAW'(cx[CW-1:0]));
		q_cell   = CAW'(CAW'(j_q) * CAW'(GRID_SIDE) + CAW'(i_q));
		ins_bad  = ({1'b0, pidx_q} >= 17'(MAX_PARTICLES)) || (cnt_rdata >= NW'(CELL_CAP));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		load      = 1'b0;
		load_idx  = 16'd0;
		load_last = 1'b1;
		load_st   = STAT_NONE;
		cnt_we    = 1'b0;
		cnt_waddr = clr_q;
		cnt_wdata = '0;
		cnt_raddr = q_cell;
		ent_we    = 1'b0;
		ent_waddr = EAW'(EAW'(cell_q) * EAW'(CELL_CAP) + EAW'(cnt_rdata));
		ent_raddr = EAW'(base_q + EAW'(e_q) + EAW'(1));
		unique case (state_q)
			ST_CLEAR: begin
				cnt_we = 1'b1;
				if (clr_q == CAW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (s_tuser)
						FUNC_NEW_FRAME:           state_d = ST_NEWF;
						FUNC_INSERT, FUNC_QUERY:  state_d = ST_MUL;
						default:                  state_d = ST_IDLE;
					endcase
				end
			end
			ST_NEWF: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_CLEAR;
				end
			end
			ST_MUL: state_d = ST_COORD;
			ST_COORD: begin
				cnt_raddr = ins_cell;
				if (func_q == FUNC_INSERT) begin
					state_d = ST_INS;
				end else if (q_empty) begin
					state_d = ST_QEND;
				end else begin
					state_d = ST_QCELL;
				end
			end
			ST_INS: begin
				if (!ins_bad) begin
					ent_we    = 1'b1;
					cnt_we    = 1'b1;
					cnt_waddr = cell_q;
					cnt_wdata = NW'(cnt_rdata + NW'(1));
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				load_st = res_st_q;
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_QCELL: state_d = ST_QCNT;
			ST_QCNT: begin
				ent_raddr = EAW'(EAW'(cell_q) * EAW'(CELL_CAP));
				state_d   = (cnt_rdata == '0) ? ST_QNEXT : ST_QENT;
			end
			ST_QENT: state_d = ST_QPUSH;
			ST_QPUSH: begin
				load_idx  = pend_q;
				load_last = 1'b0;
				load_st   = STAT_NEIGH;
				if (!pend_v_q || out_free) begin
					load    = pend_v_q;
					state_d = (NW'(e_q + NW'(1)) < n_q) ? ST_QENT : ST_QNEXT;
				end
			end
			ST_QNEXT: begin
				state_d = (i_q == x1_q && j_q == y1_q) ? ST_QEND : ST_QCELL;
			end
			ST_QEND: begin
				load_idx = pend_v_q ? pend_q : 16'd0;
				load_st  = pend_v_q ? STAT_NEIGH : STAT_NONE;
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= (clr_q == CAW'(CELLS - 1)) ? '0 : CAW'(clr_q + CAW'(1));
			end
			if (state_q == ST_COORD) begin
				pend_v_q <= 1'b0;
			end else if (state_q == ST_QPUSH && (!pend_v_q || out_free)) begin
				pend_v_q <= 1'b1;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_idx_q  <= load_idx;
			out_last_q <= load_last;
			out_st_q   <= load_st;
		end
		unique case (state_q)
			ST_IDLE: begin
				func_q <= s_tuser;
				posx_q <= $signed(s_tdata[23:0]);
				posy_q <= $signed(s_tdata[47:24]);
				pidx_q <= s_tdata[63:48];
			end
			ST_MUL: begin
				prodx_q <= 30'(posx_q * $signed({1'b0, density_q}));
				prody_q <= 30'(posy_q * $signed({1'b0, density_q}));
			end
			ST_COORD: begin
				cell_q <= ins_cell;
				x1_q   <= x1[CW-1:0];
				y0_q   <= y0[CW-1:0];
				y1_q   <= y1[CW-1:0];
				i_q    <= x0[CW-1:0];
				j_q    <= y0[CW-1:0];
			end
			ST_INS: res_st_q <= ins_bad ? STAT_FULL : STAT_NONE;
			ST_QCELL: cell_q <= q_cell;
			ST_QCNT: begin
				n_q    <= cnt_rdata;
				e_q    <= '0;
				base_q <= EAW'(EAW'(cell_q) * EAW'(CELL_CAP));
			end
			ST_QENT: ent_q <= ent_rdata;
			ST_QPUSH: begin
				if (!pend_v_q || out_free) begin
					pend_q <= ent_q;
					e_q    <= NW'(e_q + NW'(1));
				end
			end
			ST_QNEXT: begin
				if (j_q == y1_q) begin
					j_q <= y0_q;
					i_q <= CW'(i_q + CW'(1));
				end else begin
					j_q <= CW'(j_q + CW'(1));
				end
			end
			default: ;
		endcase
	end

	gbng_ram #(.WIDTH(NW), .DEPTH(CELLS)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	gbng_ram #(.WIDTH(16), .DEPTH(ENTS)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (pidx_q),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_idx_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_st_q;

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_NONE |-> m_tlast)
		else $error("empty or ack beat without last");
	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_FULL |-> m_tlast)
		else $error("drop beat without last");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we && state_q == ST_INS |-> cnt_wdata != '0 && ent_we)
		else $error("insert count write inconsistent");
	a_push_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QPUSH && pend_v_q && !out_free |=> state_q == ST_QPUSH)
		else $error("pending beat overwritten");
endmodule

// File: sim/grid_bin_neighbour_gather_unit_chk.sv
`timescale 1ns / 1ps
// Checker for the grid bin neighbour gather unit: predicts every result beat from
// accepted input beats and register writes, and compares the output stream. Uses gbng_pkg.
module grid_bin_neighbour_gather_unit_chk
	import gbng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tlast,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	output int          errors,
	output int          pending
);

	localparam int SIDE = 32;
	localparam int CAP  = 7;

	typedef struct packed {
		logic [15:0] idx;
		logic        last;
		status_t     st;
	} gather_beat_t;

	gather_beat_t    gather_q[$];
	logic [4:0]      density;
	logic [5:0]      grid_w;
	logic [5:0]      grid_h;
	int              bin_fill[SIDE*SIDE];
	logic [15:0]     bin_idx[SIDE*SIDE][CAP];

	function automatic longint cell_of(logic [23:0] pos);
		longint v;
		v = longint'($signed(pos)) * longint'(density);
		return v >>> 8;
	endfunction

	function automatic longint extent(logic [5:0] r);
		if (r < 1) return 1;
		if (r > SIDE) return SIDE;
		return r;
	endfunction

	function automatic void enqueue(gather_beat_t b);
		gather_q.insert(gather_q.size(), b);
	endfunction

	task automatic predict(logic [1:0] fn, logic [23:0] px, logic [23:0] py, logic [15:0] pid);
		longint w, h, cx, cy, x0, x1, y0, y1;
		int bin_no, k;
		gather_beat_t b;
		w = extent(grid_w);
		h = extent(grid_h);
		cx = cell_of(px);
		cy = cell_of(py);
		case (func_t'(fn))
			FUNC_NEW_FRAME: begin
				foreach (bin_fill[i]) bin_fill[i] = 0;
				enqueue('{16'd0, 1'b1, STAT_NONE});
			end
			FUNC_INSERT: begin
				if (cx < 0) cx = 0;
				if (cx > w - 1) cx = w - 1;
				if (cy < 0) cy = 0;
				if (cy > h - 1) cy = h - 1;
				bin_no = int'(cy * SIDE + cx);
				if (bin_fill[bin_no] >= CAP) begin
					enqueue('{16'd0, 1'b1, STAT_FULL});
				end else begin
					bin_idx[bin_no][bin_fill[bin_no]] = pid;
					bin_fill[bin_no]++;
					enqueue('{16'd0, 1'b1, STAT_NONE});
				end
			end
			FUNC_QUERY: begin
				x0 = (cx - 1 < 0) ? 0 : cx - 1;
				x1 = (cx + 1 > w - 1) ? w - 1 : cx + 1;
				y0 = (cy - 1 < 0) ? 0 : cy - 1;
				y1 = (cy + 1 > h - 1) ? h - 1 : cy + 1;
				k = 0;
				for (longint i = x0; i <= x1; i++) begin
					for (longint j = y0; j <= y1; j++) begin
						bin_no = int'(j * SIDE + i);
						for (int e = 0; e < bin_fill[bin_no]; e++) begin
							enqueue('{bin_idx[bin_no][e], 1'b0, STAT_NEIGH});
							k++;
						end
					end
				end
				if (k == 0) begin
					enqueue('{16'd0, 1'b1, STAT_NONE});
				end else begin
					b = gather_q.pop_back();
					b.last = 1'b1;
					enqueue(b);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		gather_beat_t exp_b;
		if (!arst_n) begin
			density = 5'd1;
			grid_w  = 6'd32;
			grid_h  = 6'd32;
			foreach (bin_fill[i]) bin_fill[i] = 0;
			gather_q.delete();
			errors  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					2'd0: density = cfg_data[4:0];
					2'd1: grid_w  = cfg_data;
					2'd2: grid_h  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict(s_tuser, s_tdata[23:0], s_tdata[47:24], s_tdata[63:48]);
			if (m_tvalid && m_tready) begin
				if (gather_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected beat: idx %h last %b status %0d",
							m_tdata, m_tlast, m_tuser);
					errors <= errors + 1;
				end else begin
					exp_b = gather_q.pop_front();
					if (m_tdata !== exp_b.idx || m_tlast !== exp_b.last || m_tuser !== exp_b.st) begin
						if (errors < 10)
							$display("mismatch: exp idx %h last %b status %0d, got idx %h last %b status %0d",
								exp_b.idx, exp_b.last, exp_b.st, m_tdata, m_tlast, m_tuser);
						errors <= errors + 1;
					end
				end
			end
		end
		pending <= gather_q.size();
	end

endmodule

// File: sim/grid_bin_neighbour_gather_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the grid bin neighbour gather unit: drives items, register writes
// and sink stalls; the checker module does the comparison. Uses gbng_pkg.
module grid_bin_neighbour_gather_unit_tb;
	import gbng_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [5:0]  cfg_data = '0;
	int          errors;
	int          pending;
	bit          stalls_on = 1'b1;
	int          quiet_cycles = 0;
	int          cur_density = 1;
	int          cur_w = 32;
	int          cur_h = 32;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	grid_bin_neighbour_gather_unit i_dut (.*);

	grid_bin_neighbour_gather_unit_chk i_chk (.*);

	always @(posedge clk)
		m_tready <= !(stalls_on && $urandom_range(99) < 21);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_beat(func_t fn, logic [23:0] px, logic [23:0] py, logic [15:0] pid);
		if (stalls_on && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {pid, py, px};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [5:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	// aim near the grid: target cells one or two off each edge, sometimes raw bits
	function automatic logic [23:0] aim_pos(int ext);
		longint v;
		int e;
		e = (ext < 1) ? 1 : (ext > 32 ? 32 : ext);
		if ($urandom_range(7) == 0) return 24'($urandom);
		v = longint'(int'($urandom_range(e + 3)) - 2) * 256 + $urandom_range(255);
		if (cur_density != 0) v = v / cur_density;
		return v[23:0];
	endfunction

	task automatic configure(int d, int w, int h);
		drain();
		write_reg(2'd0, d[5:0]);
		write_reg(2'd1, w[5:0]);
		write_reg(2'd2, h[5:0]);
		cur_density = d;
		cur_w = w;
		cur_h = h;
	endtask

	task automatic random_items(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 55)
				send_beat(FUNC_INSERT, aim_pos(cur_w), aim_pos(cur_h), 16'($urandom));
			else if (r < 90)
				send_beat(FUNC_QUERY, aim_pos(cur_w), aim_pos(cur_h), 16'($urandom));
			else if (r < 95)
				send_beat(FUNC_NEW_FRAME, 24'($urandom), 24'($urandom), 16'($urandom));
			else
				send_beat(FUNC_UNUSED, 24'($urandom), 24'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(FUNC_NEW_FRAME, 24'h0, 24'h0, 16'h0);
		send_beat(FUNC_INSERT, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
		send_beat(FUNC_INSERT, 24'h800000, 24'h800000, 16'h0000);
		for (int i = 0; i < 8; i++)
			send_beat(FUNC_INSERT, 24'h000080, 24'h000100, 16'(16'h1000 + i));
		send_beat(FUNC_INSERT, 24'h000200, 24'h000180, 16'hA5A5);
		send_beat(FUNC_QUERY, 24'h000100, 24'h000100, 16'hFFFF);
		send_beat(FUNC_QUERY, 24'h0, 24'h0, 16'h0);
		send_beat(FUNC_QUERY, 24'h7FFFFF, 24'h7FFFFF, 16'h0);
		send_beat(FUNC_QUERY, 24'h800000, 24'h800000, 16'h0);
		send_beat(FUNC_QUERY, 24'h001F00, 24'hFFFF00, 16'h0);
		send_beat(FUNC_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
		send_beat(FUNC_QUERY, 24'h000300, 24'h000300, 16'h0);
		random_items(20);

		stalls_on = 1'b0;
		configure(16, 1, 1);
		random_items(25);
		stalls_on = 1'b1;
		configure(4, 8, 5);
		send_beat(FUNC_NEW_FRAME, 24'h0, 24'h0, 16'h0);
		random_items(30);
		configure(0, 63, 0);
		random_items(20);
		configure(31, 3, 32);
		random_items(25);
		configure(7, 32, 2);
		random_items(25);

		drain();
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
